[rtl/epwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwm_pkg
// Types and constants shared by the echo pulse width meter modules.
// ----------------------------------------------------------------------------
package epwm_pkg;

   localparam int NUM_CHANNELS = 6;
   localparam int FILTER_TAPS  = 5;
   localparam int STAMP_BITS   = 16;
   localparam int CH_BITS      = 3;
   localparam int SCALE_BITS   = 20;
   localparam int LIMIT_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int PROD_BITS    = STAMP_BITS + SCALE_BITS;
   localparam int MEAS_BITS    = PROD_BITS - FRAC_BITS;
   localparam int TAP_BITS     = 16;
   localparam int TAP_IDX_BITS = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
   localparam int SUM_BITS     = TAP_BITS + $clog2(FILTER_TAPS);
   localparam int VAL_BITS     = (SUM_BITS > MEAS_BITS) ? SUM_BITS : MEAS_BITS;
   localparam int DIST_BITS    = 8;
   localparam int PTICK_BITS   = 16;

   // reciprocal for the tap average: floor(x / FILTER_TAPS) = (x * DIV_MULT) >> DIV_SHIFT
   localparam int DIV_SHIFT     = SUM_BITS + $clog2(FILTER_TAPS);
   localparam int DIV_MULT_BITS = DIV_SHIFT + 1;
   localparam longint DIV_MULT_L =
      ((64'sd1 <<< DIV_SHIFT) + FILTER_TAPS - 1) / FILTER_TAPS;
   localparam logic [DIV_MULT_BITS-1:0] DIV_MULT = DIV_MULT_L[DIV_MULT_BITS-1:0];
   localparam int DIV_PROD_BITS = SUM_BITS + DIV_MULT_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;
   localparam int RIDX_BITS = 2;

   localparam logic [RIDX_BITS-1:0] REG_MEASURE_SCALE = 2'd0;
   localparam logic [RIDX_BITS-1:0] REG_FILTER_ENABLE = 2'd1;
   localparam logic [RIDX_BITS-1:0] REG_SAT_LIMIT     = 2'd2;

   localparam logic [SCALE_BITS-1:0] MEASURE_SCALE_RST = 20'd251238;
   localparam logic                  FILTER_ENABLE_RST = 1'b0;
   localparam logic [LIMIT_BITS-1:0] SAT_LIMIT_RST     = 16'd400;

   typedef struct packed {
      logic [CH_BITS-1:0]    channel_index;
      logic [STAMP_BITS-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    out_channel;
      logic [PTICK_BITS-1:0] pulse_ticks;
      logic [DIST_BITS-1:0]  distance;
      logic                  clipped;
   } rsp_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    channel;
      logic [STAMP_BITS-1:0] width;
   } job_type;

   typedef struct packed {
      logic [SCALE_BITS-1:0] measure_scale;
      logic                  filter_enable;
      logic [LIMIT_BITS-1:0] sat_limit;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_port_type;

endpackage
`default_nettype wire

[rtl/echo_pulse_width_meter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// echo_pulse_width_meter_top
// Pulse width meter for six echo capture inputs with optional averaging.
// ----------------------------------------------------------------------------
// req channel: one capture transaction per edge (channel_index, stamp); the
//   first edge on a channel is taken as rising, the next as falling
// rsp channel: one transaction per falling edge with width, distance, clip
// csr port: measure_scale at 0x0, filter_enable at 0x4, sat_limit at 0x8;
//   write only while no transaction is in flight
// throughput: one req transaction per cycle while the queue is not full,
//   set by the history update in the filter stage
// path: from req accept to rsp valid a job goes through the queue, scale
//   multiply, filter, reciprocal multiply and output register; the queue
//   write shares the accept edge
// reset: all channels expect a rising edge, history cleared, registers at
//   their defaults, no rsp pending
// rsp stall: the pipeline holds and the 4-entry queue absorbs falling edges;
//   req_ready drops only when the queue is full
// ----------------------------------------------------------------------------
module echo_pulse_width_meter_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  epwm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output epwm_pkg::rsp_type                rsp_data,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [epwm_pkg::ADDR_BITS-1:0]   paddr,
   input  wire  [epwm_pkg::DATA_BITS-1:0]   pwdata,
   output logic [epwm_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready
);

   epwm_pkg::cfg_type                cfg_ff;
   epwm_pkg::job_port_type           push;
   epwm_pkg::job_port_type           head;
   logic                             push_ready;
   logic                             pop;
   logic                             csr_wr;
   logic [epwm_pkg::RIDX_BITS-1:0]   csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[epwm_pkg::ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.measure_scale <= epwm_pkg::MEASURE_SCALE_RST;
         cfg_ff.filter_enable <= epwm_pkg::FILTER_ENABLE_RST;
         cfg_ff.sat_limit     <= epwm_pkg::SAT_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            epwm_pkg::REG_MEASURE_SCALE: begin
               cfg_ff.measure_scale <= pwdata[epwm_pkg::SCALE_BITS-1:0];
            end
            epwm_pkg::REG_FILTER_ENABLE: begin
               cfg_ff.filter_enable <= pwdata[0];
            end
            epwm_pkg::REG_SAT_LIMIT: begin
               cfg_ff.sat_limit <= pwdata[epwm_pkg::LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         epwm_pkg::REG_MEASURE_SCALE: prdata = epwm_pkg::DATA_BITS'(cfg_ff.measure_scale);
         epwm_pkg::REG_FILTER_ENABLE: prdata = epwm_pkg::DATA_BITS'(cfg_ff.filter_enable);
         epwm_pkg::REG_SAT_LIMIT:     prdata = epwm_pkg::DATA_BITS'(cfg_ff.sat_limit);
         default:                     prdata = '0;
      endcase
   end

   epwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req_data),
      .push_ready (push_ready),
      .push       (push)
   );

   epwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   epwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/epwm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwm_front
// Edge tracker: alternates rising and falling per channel and forms widths.
// ----------------------------------------------------------------------------
module epwm_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  epwm_pkg::req_type      req,
   input  wire                    push_ready,
   output epwm_pkg::job_port_type push
);

   logic                              phase_ff [epwm_pkg::NUM_CHANNELS];
   logic                              phase_in [epwm_pkg::NUM_CHANNELS];
   logic [epwm_pkg::STAMP_BITS-1:0]   rise_ff  [epwm_pkg::NUM_CHANNELS];
   logic [epwm_pkg::STAMP_BITS-1:0]   rise_in  [epwm_pkg::NUM_CHANNELS];
   logic                              accept;
   logic                              in_range;
   logic [epwm_pkg::CH_BITS-1:0]      ch_idx;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign in_range  = 32'(req.channel_index) < epwm_pkg::NUM_CHANNELS;
   assign ch_idx    = in_range ? req.channel_index : '0;

   always_comb begin
      phase_in = phase_ff;
      rise_in  = rise_ff;
      push.valid       = 1'b0;
      push.job.channel = req.channel_index;
      push.job.width   = req.stamp - rise_ff[ch_idx];
      if (accept && in_range) begin
         if (!phase_ff[ch_idx]) begin
            rise_in[ch_idx]  = req.stamp;
            phase_in[ch_idx] = 1'b1;
         end else begin
            phase_in[ch_idx] = 1'b0;
            push.valid       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < epwm_pkg::NUM_CHANNELS; i++) begin
            phase_ff[i] <= 1'b0;
            rise_ff[i]  <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         rise_ff  <= rise_in;
      end
   end

endmodule
`default_nettype wire

[rtl/epwm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwm_queue
// Short job queue between the edge tracker and the measurement pipeline.
// ----------------------------------------------------------------------------
module epwm_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  epwm_pkg::job_port_type push,
   output logic                   push_ready,
   input  wire                    pop,
   output epwm_pkg::job_port_type head
);

   epwm_pkg::job_type                 entry_ff [epwm_pkg::QUEUE_DEPTH];
   logic [epwm_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [epwm_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [epwm_pkg::QPTR_BITS:0]      count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = count_ff != (epwm_pkg::QPTR_BITS + 1)'(epwm_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule
`default_nettype wire

[rtl/epwm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwm_back
// Measurement pipeline: scale, limit and tap history, average, saturate.
// ----------------------------------------------------------------------------
module epwm_back (
   input  wire                    clock,
   input  wire                    reset,
   input  epwm_pkg::cfg_type      cfg,
   input  epwm_pkg::job_port_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output epwm_pkg::rsp_type      rsp
);

   logic                              advance;

   // scale stage
   logic                              s1_vld_ff;
   logic [epwm_pkg::CH_BITS-1:0]      s1_ch_ff;
   logic [epwm_pkg::STAMP_BITS-1:0]   s1_width_ff;
   logic [epwm_pkg::MEAS_BITS-1:0]    s1_meas_ff, s1_meas_in;
   logic [epwm_pkg::PROD_BITS-1:0]    scale_prod;

   // filter stage
   logic                              s2_vld_ff;
   logic [epwm_pkg::CH_BITS-1:0]      s2_ch_ff;
   logic [epwm_pkg::STAMP_BITS-1:0]   s2_width_ff;
   logic [epwm_pkg::VAL_BITS-1:0]     s2_val_ff, s2_val_in;
   logic                              s2_div_ff, s2_div_in;
   logic [epwm_pkg::TAP_BITS-1:0]     hist_ff [epwm_pkg::NUM_CHANNELS][epwm_pkg::FILTER_TAPS];
   logic [epwm_pkg::TAP_BITS-1:0]     new_taps [epwm_pkg::FILTER_TAPS];
   logic [epwm_pkg::SUM_BITS-1:0]     tap_sum;
   logic                              over_limit;
   logic                              hist_wr;

   // average stage
   logic                              s3_vld_ff;
   logic [epwm_pkg::CH_BITS-1:0]      s3_ch_ff;
   logic [epwm_pkg::STAMP_BITS-1:0]   s3_width_ff;
   logic [epwm_pkg::VAL_BITS-1:0]     s3_val_ff, s3_val_in;
   logic [epwm_pkg::DIV_PROD_BITS-1:0] div_prod;

   // output register
   logic                              out_vld_ff;
   epwm_pkg::rsp_type                 out_ff, out_in;
   logic                              clip;

   assign advance   = !out_vld_ff || rsp_ready;
   assign pop       = advance && head.valid;
   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

   assign scale_prod = epwm_pkg::PROD_BITS'(head.job.width)
                     * epwm_pkg::PROD_BITS'(cfg.measure_scale);
   assign s1_meas_in = scale_prod[epwm_pkg::PROD_BITS-1:epwm_pkg::FRAC_BITS];

   always_comb begin
      over_limit  = s1_meas_ff > epwm_pkg::MEAS_BITS'(cfg.sat_limit);
      new_taps[0] = s1_meas_ff[epwm_pkg::TAP_BITS-1:0];
      for (int i = 1; i < epwm_pkg::FILTER_TAPS; i++) begin
         new_taps[i] = hist_ff[s1_ch_ff][i-1];
      end
      tap_sum = '0;
      for (int i = 0; i < epwm_pkg::FILTER_TAPS; i++) begin
         tap_sum = tap_sum + epwm_pkg::SUM_BITS'(new_taps[i]);
      end
      hist_wr   = advance && s1_vld_ff && cfg.filter_enable && !over_limit;
      s2_div_in = cfg.filter_enable && !over_limit;
      if (!cfg.filter_enable) begin
         s2_val_in = epwm_pkg::VAL_BITS'(s1_meas_ff);
      end else if (over_limit) begin
         s2_val_in = epwm_pkg::VAL_BITS'(cfg.sat_limit);
      end else begin
         s2_val_in = epwm_pkg::VAL_BITS'(tap_sum);
      end
   end

   assign div_prod = epwm_pkg::DIV_PROD_BITS'(s2_val_ff[epwm_pkg::SUM_BITS-1:0])
                   * epwm_pkg::DIV_PROD_BITS'(epwm_pkg::DIV_MULT);
   assign s3_val_in = s2_div_ff
                    ? epwm_pkg::VAL_BITS'(div_prod >> epwm_pkg::DIV_SHIFT)
                    : s2_val_ff;

   always_comb begin
      clip               = s3_val_ff > epwm_pkg::VAL_BITS'(epwm_pkg::DIST_MAX);
      out_in.out_channel = s3_ch_ff;
      out_in.pulse_ticks = s3_width_ff;
      out_in.distance    = clip ? epwm_pkg::DIST_MAX : s3_val_ff[epwm_pkg::DIST_BITS-1:0];
      out_in.clipped     = clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= head.valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ch_ff    <= head.job.channel;
         s1_width_ff <= head.job.width;
         s1_meas_ff  <= s1_meas_in;
         s2_ch_ff    <= s1_ch_ff;
         s2_width_ff <= s1_width_ff;
         s2_val_ff   <= s2_val_in;
         s2_div_ff   <= s2_div_in;
         s3_ch_ff    <= s2_ch_ff;
         s3_width_ff <= s2_width_ff;
         s3_val_ff   <= s3_val_in;
         out_ff      <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < epwm_pkg::NUM_CHANNELS; c++) begin
            for (int t = 0; t < epwm_pkg::FILTER_TAPS; t++) begin
               hist_ff[c][t] <= '0;
            end
         end
      end else if (hist_wr) begin
         for (int t = 0; t < epwm_pkg::FILTER_TAPS; t++) begin
            hist_ff[s1_ch_ff][t] <= new_taps[t];
         end
      end
   end

endmodule
`default_nettype wire

[rtl/epwm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwm_checker
// Port-level checks for the echo pulse width meter, bound to the top level.
// ----------------------------------------------------------------------------
module epwm_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input epwm_pkg::rsp_type rsp
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled rsp transaction changed");

   a_clip_means_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.clipped |-> rsp.distance == epwm_pkg::DIST_MAX)
      else $error("clipped rsp without saturated distance");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp.out_channel) < epwm_pkg::NUM_CHANNELS)
      else $error("rsp for a channel out of range");

endmodule

bind echo_pulse_width_meter_top epwm_checker u_epwm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp_data)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the echo pulse width meter.
// Capture transactions go in on the req channel and the bench tracks each
// channel's edge phase, rise stamp and tap history to work out the width and
// distance of every completed pulse. Results on the rsp channel are compared
// field by field in order. Registers are written and read back over the csr
// port between phases, with both channels idling at random.
// ----------------------------------------------------------------------------

class pulse_tracker;
   epwm_pkg::rsp_type               pending_pulses[$];
   int unsigned                     error_count;
   logic [epwm_pkg::SCALE_BITS-1:0] scale;
   logic                            filter_on;
   logic [epwm_pkg::LIMIT_BITS-1:0] limit;
   logic                            awaiting_fall [epwm_pkg::NUM_CHANNELS];
   logic [epwm_pkg::STAMP_BITS-1:0] rise_at [epwm_pkg::NUM_CHANNELS];
   logic [epwm_pkg::TAP_BITS-1:0]   taps [epwm_pkg::NUM_CHANNELS][epwm_pkg::FILTER_TAPS];

   function new();
      error_count = 0;
      scale       = epwm_pkg::MEASURE_SCALE_RST;
      filter_on   = epwm_pkg::FILTER_ENABLE_RST;
      limit       = epwm_pkg::SAT_LIMIT_RST;
      for (int c = 0; c < epwm_pkg::NUM_CHANNELS; c++) begin
         awaiting_fall[c] = 1'b0;
         rise_at[c]       = '0;
         for (int t = 0; t < epwm_pkg::FILTER_TAPS; t++) taps[c][t] = '0;
      end
   endfunction

   function void set_register(logic [epwm_pkg::RIDX_BITS-1:0] idx,
                              logic [epwm_pkg::DATA_BITS-1:0] value);
      case (idx)
         epwm_pkg::REG_MEASURE_SCALE: scale = value[epwm_pkg::SCALE_BITS-1:0];
         epwm_pkg::REG_FILTER_ENABLE: filter_on = value[0];
         epwm_pkg::REG_SAT_LIMIT:     limit = value[epwm_pkg::LIMIT_BITS-1:0];
         default: ;
      endcase
   endfunction

   function logic [epwm_pkg::DATA_BITS-1:0] register_value(
      logic [epwm_pkg::RIDX_BITS-1:0] idx);
      case (idx)
         epwm_pkg::REG_MEASURE_SCALE: return epwm_pkg::DATA_BITS'(scale);
         epwm_pkg::REG_FILTER_ENABLE: return epwm_pkg::DATA_BITS'(filter_on);
         epwm_pkg::REG_SAT_LIMIT:     return epwm_pkg::DATA_BITS'(limit);
         default:                     return '0;
      endcase
   endfunction

   function void note_capture(epwm_pkg::req_type item);
      int unsigned                     ch;
      logic [epwm_pkg::STAMP_BITS-1:0] width;
      logic [epwm_pkg::PROD_BITS-1:0]  product;
      logic [epwm_pkg::MEAS_BITS-1:0]  meas;
      logic [epwm_pkg::MEAS_BITS-1:0]  level;
      logic [epwm_pkg::SUM_BITS-1:0]   sum;
      epwm_pkg::rsp_type               pulse;
      if (item.channel_index >= epwm_pkg::NUM_CHANNELS) return;
      ch = 32'(item.channel_index);
      if (!awaiting_fall[ch]) begin
         awaiting_fall[ch] = 1'b1;
         rise_at[ch]       = item.stamp;
         return;
      end
      awaiting_fall[ch] = 1'b0;
      width   = item.stamp - rise_at[ch];
      product = epwm_pkg::PROD_BITS'(width) * epwm_pkg::PROD_BITS'(scale);
      meas    = product[epwm_pkg::PROD_BITS-1:epwm_pkg::FRAC_BITS];
      level   = meas;
      if (filter_on) begin
         if (meas > epwm_pkg::MEAS_BITS'(limit)) begin
            level = epwm_pkg::MEAS_BITS'(limit);
         end else begin
            for (int t = epwm_pkg::FILTER_TAPS - 1; t > 0; t--) taps[ch][t] = taps[ch][t-1];
            taps[ch][0] = meas[epwm_pkg::TAP_BITS-1:0];
            sum = '0;
            for (int t = 0; t < epwm_pkg::FILTER_TAPS; t++) begin
               sum += epwm_pkg::SUM_BITS'(taps[ch][t]);
            end
            level = epwm_pkg::MEAS_BITS'(sum / epwm_pkg::FILTER_TAPS);
         end
      end
      pulse.out_channel = item.channel_index;
      pulse.pulse_ticks = width;
      pulse.clipped     = (level > epwm_pkg::MEAS_BITS'(epwm_pkg::DIST_MAX));
      pulse.distance    = pulse.clipped ? epwm_pkg::DIST_MAX
                                        : level[epwm_pkg::DIST_BITS-1:0];
      pending_pulses.push_back(pulse);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function void check_pulse(epwm_pkg::rsp_type got);
      epwm_pkg::rsp_type want;
      if (pending_pulses.size() == 0) begin
         $error("unexpected pulse transaction on channel %0d", got.out_channel);
         error_count++;
         return;
      end
      want = pending_pulses.pop_front();
      compare_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
      compare_field("pulse_ticks", 32'(want.pulse_ticks), 32'(got.pulse_ticks));
      compare_field("distance", 32'(want.distance), 32'(got.distance));
      compare_field("clipped", 32'(want.clipped), 32'(got.clipped));
   endfunction
endclass

module tb;

   localparam logic [epwm_pkg::RIDX_BITS-1:0] REG_UNMAPPED = 2'd3;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   epwm_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   epwm_pkg::rsp_type              rsp_data;
   logic                           psel      = 1'b0;
   logic                           penable   = 1'b0;
   logic                           pwrite    = 1'b0;
   logic [epwm_pkg::ADDR_BITS-1:0] paddr     = '0;
   logic [epwm_pkg::DATA_BITS-1:0] pwdata    = '0;
   logic [epwm_pkg::DATA_BITS-1:0] prdata;
   logic                           pready;

   logic                            calm = 1'b0;
   logic [epwm_pkg::STAMP_BITS-1:0] last_stamp [epwm_pkg::NUM_CHANNELS];
   pulse_tracker                    sb;

   echo_pulse_width_meter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_capture(req_data);
         if (rsp_valid && rsp_ready) sb.check_pulse(rsp_data);
      end
   end

   task automatic send_capture(input logic [epwm_pkg::CH_BITS-1:0] ch,
                               input logic [epwm_pkg::STAMP_BITS-1:0] stamp);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_data.channel_index <= ch;
      req_data.stamp         <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_pulse(input logic [epwm_pkg::CH_BITS-1:0] ch,
                             input logic [epwm_pkg::STAMP_BITS-1:0] rise,
                             input logic [epwm_pkg::STAMP_BITS-1:0] fall);
      send_capture(ch, rise);
      send_capture(ch, fall);
   endtask

   // mostly rise/fall sequences with varied widths, some out-of-range noise
   task automatic send_random_capture();
      int unsigned                     ch;
      int unsigned                     pick;
      logic [epwm_pkg::STAMP_BITS-1:0] delta;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_capture(epwm_pkg::CH_BITS'($urandom_range(7, epwm_pkg::NUM_CHANNELS)),
                      epwm_pkg::STAMP_BITS'($urandom));
      end else begin
         ch   = $urandom_range(epwm_pkg::NUM_CHANNELS - 1);
         pick = $urandom_range(99);
         if (pick < 50)      delta = epwm_pkg::STAMP_BITS'($urandom_range(120));
         else if (pick < 75) delta = epwm_pkg::STAMP_BITS'($urandom_range(1023));
         else if (pick < 90) delta = epwm_pkg::STAMP_BITS'($urandom);
         else                delta = epwm_pkg::STAMP_BITS'(16'hFFFF - $urandom_range(15));
         last_stamp[ch] = last_stamp[ch] + delta;
         send_capture(epwm_pkg::CH_BITS'(ch), last_stamp[ch]);
      end
   endtask

   // drop valid, wait for all pulses, then idle to let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pulses.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [epwm_pkg::RIDX_BITS-1:0] idx,
                                 input logic [epwm_pkg::DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic check_register(input logic [epwm_pkg::RIDX_BITS-1:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== sb.register_value(idx)) begin
         $error("register %0d: expected %0d, got %0d", idx, sb.register_value(idx), prdata);
         sb.error_count++;
      end
   endtask

   task automatic verify_registers();
      check_register(epwm_pkg::REG_MEASURE_SCALE);
      check_register(epwm_pkg::REG_FILTER_ENABLE);
      check_register(epwm_pkg::REG_SAT_LIMIT);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input logic [epwm_pkg::DATA_BITS-1:0] scale_word,
                                 input logic [epwm_pkg::DATA_BITS-1:0] filter_word,
                                 input logic [epwm_pkg::DATA_BITS-1:0] limit_word);
      write_register(epwm_pkg::REG_MEASURE_SCALE, scale_word);
      write_register(epwm_pkg::REG_FILTER_ENABLE, filter_word);
      write_register(epwm_pkg::REG_SAT_LIMIT, limit_word);
      write_register(REG_UNMAPPED, $urandom);
      verify_registers();
   endtask

   initial begin
      logic [epwm_pkg::DATA_BITS-1:0] scale_word;
      logic [epwm_pkg::DATA_BITS-1:0] filter_word;
      logic [epwm_pkg::DATA_BITS-1:0] limit_word;
      sb = new();
      for (int c = 0; c < epwm_pkg::NUM_CHANNELS; c++) begin
         last_stamp[c] = epwm_pkg::STAMP_BITS'($urandom);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      verify_registers();

      // default settings, filter off
      send_pulse(3'd0, 16'd0, 16'd0);
      send_pulse(3'd1, 16'd0, 16'hFFFF);
      send_pulse(3'd2, 16'd65530, 16'd20);
      send_capture(3'd6, 16'd123);
      send_capture(3'd7, 16'hFFFF);
      send_pulse(3'd3, 16'd1000, 16'd1066);
      send_pulse(3'd4, 16'd5, 16'd72);
      send_pulse(3'd5, 16'hAAAA, 16'h5555);
      send_capture(3'd5, 16'd300);
      send_capture(3'd0, 16'd400);
      send_capture(3'd5, 16'd350);
      send_capture(3'd0, 16'd410);

      // zero scale, zero limit
      settle();
      apply_settings(32'd0, 32'hFFFF_FFF1, 32'hFFFF_0000);
      send_pulse(3'd0, 16'd0, 16'd1000);
      send_pulse(3'd2, 16'hFFFF, 16'hFFFE);

      // full scale, full limit
      settle();
      apply_settings(32'hFFFF_FFFF, 32'd1, 32'h0000_FFFF);
      send_pulse(3'd1, 16'd7, 16'd8);
      send_pulse(3'd1, 16'd0, 16'hFFFF);

      // averaging below the limit
      settle();
      apply_settings(32'(epwm_pkg::MEASURE_SCALE_RST), 32'd1, 32'(epwm_pkg::SAT_LIMIT_RST));
      for (int i = 0; i < 6; i++) send_pulse(3'd3, 16'(i * 500), 16'(i * 500 + 40 + i * 12));

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         calm = (phase == 3);
         case ($urandom_range(4))
            0:       scale_word = 32'd0;
            1:       scale_word = 32'hFFFF_FFFF;
            2:       scale_word = 32'(epwm_pkg::MEASURE_SCALE_RST);
            3:       scale_word = $urandom_range(300000);
            default: scale_word = $urandom;
         endcase
         filter_word = ($urandom & ~32'd1) | 32'($urandom_range(3) != 0);
         case ($urandom_range(3))
            0:       limit_word = 32'd0;
            1:       limit_word = 32'h0000_FFFF;
            2:       limit_word = $urandom_range(1000);
            default: limit_word = $urandom;
         endcase
         apply_settings(scale_word, filter_word, limit_word);
         repeat (50) send_random_capture();
      end

      calm = 1'b0;
      req_valid <= 1'b0;
      while (sb.pending_pulses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_pulses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
